@@ hw/rtl/assert_macros.svh @@
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked every clock, idle during reset.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/btbp_pkg.sv @@
package btbp_pkg;

	localparam int TOTAL_ENTRIES = 16;
	localparam int ADDR_BITS     = 32;
	localparam int WAYS          = 4;
	localparam int WAY_W         = 2;
	localparam int PLRU_W        = 3;
	localparam int NUM_SETS      = TOTAL_ENTRIES / WAYS;
	localparam int SET_W         = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int TAG_W         = (ADDR_BITS < 32) ? ADDR_BITS : 32;

	localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_FLIP   = 2'd1;
	localparam logic [1:0] KIND_INSERT = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] branch_addr;
		logic [31:0] new_target;
		logic        initial_taken;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        predict_taken;
		logic [31:0] predicted_target;
	} rsp_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [31:0]      target;
		logic             taken;
	} way_ent_t;

	typedef way_ent_t [WAYS-1:0] set_row_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] hit_way;
		logic [WAY_W-1:0] victim_way;
	} sel_t;

	function automatic logic [SET_W-1:0] set_of(input logic [31:0] addr);
		return addr[SET_W-1:0] & SET_MASK;
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] addr);
		return addr[TAG_W-1:0];
	endfunction

	// Tree PLRU: bit 0 root, bit 1 ways 0/1, bit 2 ways 2/3.
	function automatic logic [PLRU_W-1:0] plru_touch(input logic [PLRU_W-1:0] b,
			input logic [WAY_W-1:0] way);
		logic [PLRU_W-1:0] r;
		r = b;
		case (way)
			2'd0: begin
				r[0] = 1'b1;
				r[1] = 1'b1;
			end
			2'd1: begin
				r[0] = 1'b1;
				r[1] = 1'b0;
			end
			2'd2: begin
				r[0] = 1'b0;
				r[2] = 1'b1;
			end
			default: begin
				r[0] = 1'b0;
				r[2] = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/btbp_ram.sv @@
module btbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/btbp_way_sel.sv @@
module btbp_way_sel
	import btbp_pkg::*;
(
	input  set_row_t          row,
	input  logic [WAYS-1:0]   valid,
	input  logic [PLRU_W-1:0] plru,
	input  logic [TAG_W-1:0]  tag,
	output sel_t              sel
);

	logic [WAYS-1:0] match;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = valid[w] && (row[w].tag == tag);
		end
	end

	// lowest matching way wins
	always_comb begin
		sel.hit     = |match;
		sel.hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				sel.hit_way = WAY_W'(w);
			end
		end
		if (!plru[0]) begin
			sel.victim_way = plru[1] ? 2'd1 : 2'd0;
		end else begin
			sel.victim_way = plru[2] ? 2'd3 : 2'd2;
		end
	end

endmodule

@@ hw/rtl/branch_target_buffer_plru.sv @@
// Branch target buffer, 4-way sets, tree pseudo-LRU, one taken bit per entry.
// done and rsp are registered on the edge that ends ST_LOOK, the state that
// the accept moves to; the result is taken while done is high.
// No new request is taken while busy (ST_LOOK); the set row read issued on the
// accept edge comes back in the next cycle and is written back at its end.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset (arst_n low, async): no entry valid, all PLRU bits zero, idle.
module branch_target_buffer_plru
	import btbp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

`include "assert_macros.svh"

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t state_q;
	logic   done_q;
	rsp_t   rsp_q;

	req_t   req_s1;

	// valid bits and PLRU live in flops so reset clears them at once;
	// tags, targets and taken bits share one row per set in the RAM
	logic [NUM_SETS-1:0][WAYS-1:0] valid_q;
	logic [NUM_SETS-1:0][PLRU_W-1:0] plru_q;

	logic       accept;
	logic [SET_W-1:0] set_s1;
	set_row_t   rd_row;
	set_row_t   wr_row;
	logic       ram_we;
	sel_t       sel;
	way_ent_t   hit_ent;
	rsp_t       rsp_d;
	logic [PLRU_W-1:0] plru_d;
	logic       valid_set;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign set_s1 = set_of(req_s1.branch_addr);

	// One row per set: the read is issued on the accept edge, the
	// write-back on the following edge. The next read comes no earlier
	// than the edge after that, so it always sees the updated row.
	btbp_ram #(
		.WIDTH($bits(set_row_t)),
		.DEPTH(NUM_SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(set_s1),
		.wdata(wr_row),
		.re   (accept),
		.raddr(set_of(req.branch_addr)),
		.rdata(rd_row)
	);

	btbp_way_sel u_way_sel (
		.row  (rd_row),
		.valid(valid_q[set_s1]),
		.plru (plru_q[set_s1]),
		.tag  (tag_of(req_s1.branch_addr)),
		.sel  (sel)
	);

	assign hit_ent = rd_row[sel.hit_way];

	// read-modify-write of the set row
	always_comb begin
		wr_row    = rd_row;
		ram_we    = 1'b0;
		rsp_d     = '0;
		plru_d    = plru_q[set_s1];
		valid_set = 1'b0;
		if (state_q == ST_LOOK) begin
			case (req_s1.kind)
				KIND_LOOKUP: begin
					if (sel.hit) begin
						rsp_d.hit              = 1'b1;
						rsp_d.predict_taken    = hit_ent.taken;
						rsp_d.predicted_target = hit_ent.taken ? hit_ent.target : '0;
						plru_d                 = plru_touch(plru_q[set_s1], sel.hit_way);
					end
				end
				KIND_FLIP: begin
					// PLRU left alone on a flip
					if (sel.hit) begin
						wr_row[sel.hit_way].taken = ~hit_ent.taken;
						ram_we                    = 1'b1;
						rsp_d.hit                 = 1'b1;
						rsp_d.predict_taken       = ~hit_ent.taken;
						rsp_d.predicted_target    = hit_ent.taken ? '0 : hit_ent.target;
					end
				end
				KIND_INSERT: begin
					// always the victim, even if the address is already present
					wr_row[sel.victim_way] = '{
						tag:    tag_of(req_s1.branch_addr),
						target: req_s1.new_target,
						taken:  req_s1.initial_taken
					};
					ram_we    = 1'b1;
					valid_set = 1'b1;
					plru_d    = plru_touch(plru_q[set_s1], sel.victim_way);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					done_q  <= 1'b1;
					rsp_q   <= rsp_d;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			plru_q  <= '0;
		end else if (state_q == ST_LOOK) begin
			plru_q[set_s1] <= plru_d;
			if (valid_set) begin
				valid_q[set_s1][sel.victim_way] <= 1'b1;
			end
		end
	end

	`ASSERT_IMP(a_done_follows_look, done, $past(state_q == ST_LOOK))
	`ASSERT_NXT(a_accept_goes_busy, accept, busy && !done)
	`ASSERT_CLK(a_no_rw_overlap, !(ram_we && accept))
	`ASSERT_IMP(a_miss_zero, done && !rsp.hit, !rsp.predict_taken && rsp.predicted_target == '0)
	`ASSERT_NXT(a_insert_valid, state_q == ST_LOOK && req_s1.kind == KIND_INSERT,
		valid_q[$past(set_s1)][$past(sel.victim_way)])

endmodule

@@ bench/branch_target_buffer_plru_test.sv @@
`timescale 1ns / 100ps

module branch_target_buffer_plru_test;
	import btbp_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_OPS     = 600;
	localparam int POOL_SIZE      = 12;
	localparam int MAX_REPORTS    = 10;
	// Generous bound on run length (each request's gap, the turnaround and any drains).
	localparam longint TIMEOUT_CYCLES = 200_000;

	// The only encoding the package leaves unnamed; the block must ignore it.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// One queued request plus how the driver should present it.
	typedef struct {
		req_t        cmd;
		int unsigned gap;    // idle cycles before start is raised
		bit          drain;  // hold off until every response is back
	} btb_op_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	branch_target_buffer_plru DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the buffer contents. Tags and targets are only read
	// for valid entries, so their startup value never matters.
	logic [31:0]       shadow_tag    [TOTAL_ENTRIES];
	logic [31:0]       shadow_target [TOTAL_ENTRIES];
	bit                shadow_taken  [TOTAL_ENTRIES];
	bit                shadow_valid  [TOTAL_ENTRIES];
	bit [PLRU_W-1:0]   shadow_plru   [NUM_SETS];

	btb_op_t     btb_ops[$];         // requests waiting to be driven
	rsp_t        predicted_rsps[$];  // responses owed by the block, oldest first
	int unsigned req_sent     = 0;   // driver side, blocking
	int unsigned rsp_seen     = 0;   // monitor side, nonblocking
	int unsigned mismatch_cnt = 0;
	logic [31:0] addr_pool[POOL_SIZE];

	initial begin
		for (int i = 0; i < TOTAL_ENTRIES; i++) begin
			shadow_tag[i]    = '0;
			shadow_target[i] = '0;
			shadow_taken[i]  = 1'b0;
			shadow_valid[i]  = 1'b0;
		end
		for (int s = 0; s < NUM_SETS; s++)
			shadow_plru[s] = '0;
	end

	// Tree PLRU update: root points away from the touched half, the leaf
	// bit away from the touched way.
	function automatic bit [PLRU_W-1:0] plru_mark(input bit [PLRU_W-1:0] b,
			input int unsigned way);
		bit [PLRU_W-1:0] r;
		r = b;
		if (way < 2) begin
			r[0] = 1'b1;
			r[1] = (way == 0);
		end else begin
			r[0] = 1'b0;
			r[2] = (way == 2);
		end
		return r;
	endfunction

	// Applies one request to the shadow state and returns the response the
	// block owes for it.
	function automatic rsp_t btb_predict(input req_t r);
		rsp_t        o;
		int unsigned set_idx;
		int          hit_idx;
		int unsigned vway;
		int unsigned slot;
		o       = '0;
		set_idx = r.branch_addr % NUM_SETS;
		// Scan high to low so the lowest matching way wins on duplicates.
		hit_idx = -1;
		for (int w = WAYS - 1; w >= 0; w--)
			if (shadow_valid[set_idx * WAYS + w] &&
					shadow_tag[set_idx * WAYS + w] == r.branch_addr)
				hit_idx = set_idx * WAYS + w;
		case (r.kind)
			KIND_LOOKUP: begin
				if (hit_idx >= 0) begin
					o.hit              = 1'b1;
					o.predict_taken    = shadow_taken[hit_idx];
					o.predicted_target = shadow_taken[hit_idx] ? shadow_target[hit_idx] : '0;
					shadow_plru[set_idx] = plru_mark(shadow_plru[set_idx],
						hit_idx - set_idx * WAYS);
				end
			end
			KIND_FLIP: begin
				// Flip leaves the PLRU alone and reports the post-flip state.
				if (hit_idx >= 0) begin
					shadow_taken[hit_idx] = ~shadow_taken[hit_idx];
					o.hit              = 1'b1;
					o.predict_taken    = shadow_taken[hit_idx];
					o.predicted_target = shadow_taken[hit_idx] ? shadow_target[hit_idx] : '0;
				end
			end
			KIND_INSERT: begin
				// Victim always comes from the tree, even if the tag is already
				// present or an invalid way exists. Response stays all zero.
				if (shadow_plru[set_idx][0])
					vway = shadow_plru[set_idx][2] ? 3 : 2;
				else
					vway = shadow_plru[set_idx][1] ? 1 : 0;
				slot = set_idx * WAYS + vway;
				shadow_tag[slot]    = r.branch_addr;
				shadow_target[slot] = r.new_target;
				shadow_taken[slot]  = r.initial_taken;
				shadow_valid[slot]  = 1'b1;
				shadow_plru[set_idx] = plru_mark(shadow_plru[set_idx], vway);
			end
			default: ;  // unused kind: no state change, zero response
		endcase
		return o;
	endfunction

	task automatic add_op(input logic [1:0] kind, input logic [31:0] addr,
			input logic [31:0] tgt, input logic taken, input int unsigned gap,
			input bit drain);
		btb_op_t op;
		op.cmd.kind          = kind;
		op.cmd.branch_addr   = addr;
		op.cmd.new_target    = tgt;
		op.cmd.initial_taken = taken;
		op.gap               = gap;
		op.drain             = drain;
		btb_ops.push_back(op);
	endtask

	task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t: %s: expected hit=%0b taken=%0b target=%h, got hit=%0b taken=%0b target=%h",
				$time, what, want.hit, want.predict_taken, want.predicted_target,
				got.hit, got.predict_taken, got.predicted_target);
	endtask

	// Driver: a request goes in at an edge with start high and busy low.
	// start stays high across back-to-back requests; it is never dropped
	// and raised within the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				predicted_rsps.push_back(btb_predict(req));
				req_sent++;
			end
			// Pick the next request once the current one has gone in.
			if (!start || !busy) begin
				if (btb_ops.size() == 0) begin
					start <= 1'b0;
				end else if (btb_ops[0].gap != 0) begin
					btb_ops[0].gap = btb_ops[0].gap - 1;
					start <= 1'b0;
				end else if (btb_ops[0].drain && req_sent != rsp_seen) begin
					// Hold until the block has answered everything.
					start <= 1'b0;
				end else begin
					req   <= btb_ops[0].cmd;
					start <= 1'b1;
					void'(btb_ops.pop_front());
				end
			end
		end
	end

	// Monitor: the response is valid for exactly the cycle done is high.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (predicted_rsps.size() == 0) begin
				report_mismatch("response with no request outstanding", '0, rsp);
			end else begin
				if (rsp.hit !== predicted_rsps[0].hit ||
						rsp.predict_taken !== predicted_rsps[0].predict_taken ||
						rsp.predicted_target !== predicted_rsps[0].predicted_target)
					report_mismatch("response mismatch", predicted_rsps[0], rsp);
				void'(predicted_rsps.pop_front());
			end
			rsp_seen <= rsp_seen + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned pick;
		bit          burst;
		logic [1:0]  op_kind;
		logic [31:0] op_addr;
		logic [31:0] op_tgt;

		// Directed: empty-table misses, both predictor states, flip on hit
		// and miss, unused kind, duplicate tag (lowest way must win), and
		// enough inserts into set 0 to force evictions.
		add_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1, 1'b0);
		add_op(KIND_FLIP,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
		add_op(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 2, 1'b0);
		add_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_FLIP,   32'h0000_0000, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 3, 1'b0);
		add_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1, 1'b0);
		add_op(KIND_FLIP,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
		add_op(KIND_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1, 0, 1'b1);
		add_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_FLIP,   32'h0000_0000, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_INSERT, 32'h0000_0010, 32'h0000_0010, 1'b1, 2, 1'b0);
		add_op(KIND_INSERT, 32'h0000_0020, 32'h0000_0020, 1'b0, 0, 1'b0);
		add_op(KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1, 0, 1'b0);
		add_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1, 1'b0);
		add_op(KIND_LOOKUP, 32'h0000_0010, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_LOOKUP, 32'h0000_0020, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 0, 1'b0);
		add_op(KIND_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1, 1'b0);
		add_op(KIND_LOOKUP, 32'h5555_5555, 32'h0000_0000, 1'b0, 0, 1'b0);
		add_op(KIND_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, 0, 1'b0);

		// Random: mostly addresses from a small pool so sets fill, hit,
		// collide and evict; now and then a fresh address as noise.
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
		burst = 1'b0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			// New pacing mode and one fresh pool address every 40 requests.
			if (n % 40 == 0) begin
				burst = ($urandom_range(0, 2) == 0);
				addr_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op_kind = KIND_LOOKUP;
			else if (pick < 65)
				op_kind = KIND_FLIP;
			else if (pick < 95)
				op_kind = KIND_INSERT;
			else
				op_kind = KIND_UNUSED;
			op_addr = ($urandom_range(0, 99) < 85) ?
				addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
			pick = $urandom_range(0, 9);
			op_tgt = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
			add_op(op_kind, op_addr, op_tgt, 1'($urandom_range(0, 1)),
				burst ? 0 : $urandom_range(0, 19), $urandom_range(0, 79) == 0);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything driven and answered, then a few idle cycles to
		// catch stray strobes.
		while (btb_ops.size() != 0 || start || rsp_seen != req_sent)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (predicted_rsps.size() != 0)
			report_mismatch("responses never returned", predicted_rsps[0], '0);

		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Test completed with failures");
		$finish;
	end

endmodule
